[rtl/core/drus_pkg.sv]
// Shared types, constants and the reciprocal table for the Rem union engine.
package drus_pkg;

  localparam int VERTEX_COUNT   = 4096;
  localparam int VW             = $clog2(VERTEX_COUNT);
  localparam int STEP_W         = VW + 1;
  localparam int MAX_PARTITIONS = 64;
  localparam int OWN_W          = $clog2(MAX_PARTITIONS);
  localparam int CNT_W          = OWN_W + 1;

  // Reciprocal m = ceil(2^RECIP_SHIFT / c) makes (v * m) >> RECIP_SHIFT equal to
  // floor(v / c) for every vertex v and every count c up to MAX_PARTITIONS.
  localparam int RECIP_SHIFT    = VW + OWN_W;
  localparam int RECIP_W        = RECIP_SHIFT + 1;
  localparam int PROD_W         = VW + RECIP_W;

  localparam int OPCODE_W       = 2;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = CNT_W;
  localparam int IN_DATA_W      = 40;
  localparam int OUT_DATA_W     = 56;

  typedef logic [VW-1:0]       vertex_t;
  typedef logic [STEP_W-1:0]   step_t;
  typedef logic [OWN_W-1:0]    owner_t;
  typedef logic [CNT_W-1:0]    count_t;
  typedef logic [RECIP_W-1:0]  recip_t;
  typedef logic [OPCODE_W-1:0] opcode_t;
  typedef logic [MAX_PARTITIONS-1:0][RECIP_W-1:0] recip_tbl_t;

  localparam opcode_t OP_WRITE = 2'd0;
  localparam opcode_t OP_UNION = 2'd1;
  localparam opcode_t OP_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PARTITION_ID    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTITION_COUNT = 1'b1;

  // Long division by shift and subtract; evaluated once when the table is built.
  function automatic recip_tbl_t build_recip();
    recip_tbl_t               tbl;
    logic [RECIP_SHIFT+1:0]   num;
    logic [RECIP_SHIFT+1:0]   quo;
    logic [CNT_W:0]           rem;
    logic [CNT_W:0]           dv;
    tbl = '0;
    for (int i = 0; i < MAX_PARTITIONS; i++) begin
      num = (RECIP_SHIFT+2)'(1 << RECIP_SHIFT) + (RECIP_SHIFT+2)'(i);
      dv  = (CNT_W+1)'(i + 1);
      rem = '0;
      quo = '0;
      for (int b = RECIP_SHIFT + 1; b >= 0; b--) begin
        rem = {rem[CNT_W-1:0], num[b]};
        if (rem >= dv) begin
          rem    = rem - dv;
          quo[b] = 1'b1;
        end
      end
      tbl[i] = quo[RECIP_W-1:0];
    end
    return tbl;
  endfunction

  localparam recip_tbl_t RECIP_TBL = build_recip();

  // A count of zero acts as one; a count above the maximum saturates.
  function automatic count_t eff_count(count_t c);
    count_t r;
    r = c;
    if (c == '0) begin
      r = count_t'(1);
    end else if (c > count_t'(MAX_PARTITIONS)) begin
      r = count_t'(MAX_PARTITIONS);
    end
    return r;
  endfunction

endpackage

[rtl/core/drus_owner.sv]
// Registered owner unit: vertex modulo partition count by reciprocal multiply.
module drus_owner (
  input  logic             clk,
  input  drus_pkg::vertex_t v,
  input  drus_pkg::count_t  cnt,
  output drus_pkg::owner_t  rem
);

  drus_pkg::recip_t                          m;
  logic [drus_pkg::CNT_W-1:0]                cnt_m1;
  logic [drus_pkg::PROD_W-1:0]               prod_r;
  drus_pkg::vertex_t                         v_r;
  drus_pkg::count_t                          cnt_r;
  drus_pkg::vertex_t                         quo;
  logic [drus_pkg::VW+drus_pkg::CNT_W-1:0]   qc;
  drus_pkg::vertex_t                         diff;

  // The count is already clamped to 1..MAX_PARTITIONS, so count-1 indexes the table.
  assign cnt_m1 = cnt - drus_pkg::CNT_W'(1);
  assign m      = drus_pkg::RECIP_TBL[cnt_m1[drus_pkg::OWN_W-1:0]];

  always_ff @(posedge clk) begin
    prod_r <= drus_pkg::PROD_W'(v) * drus_pkg::PROD_W'(m);
    v_r    <= v;
    cnt_r  <= cnt;
  end

  assign quo  = prod_r[drus_pkg::RECIP_SHIFT+drus_pkg::VW-1:drus_pkg::RECIP_SHIFT];
  assign qc   = (drus_pkg::VW+drus_pkg::CNT_W)'(quo) * (drus_pkg::VW+drus_pkg::CNT_W)'(cnt_r);
  assign diff = v_r - qc[drus_pkg::VW-1:0];
  assign rem  = diff[drus_pkg::OWN_W-1:0];

endmodule

[rtl/core/distributed_rem_union_step.sv]
// Top level: one partition's Rem union-find engine around a parent memory.
// A write word goes straight to the finish state, a read word reads the memory first, and a union
// task walks x, walks y if local (else writes its supplied parent), links roots, may forward a task.
// Throughput: one word in flight; the next is taken only after the previous result loads.
// Reset (rst_n low, synchronous) clears the controller, the output valid and the
// configuration registers; the parent memory is not cleared and holds garbage until written.
module distributed_rem_union_step (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [drus_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [drus_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // Input words.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [drus_pkg::IN_DATA_W-1:0]    in_tdata,   // first_vertex, second_vertex, remote_parent
  input  logic [drus_pkg::OPCODE_W-1:0]     in_tuser,   // opcode
  // Result words.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [drus_pkg::OUT_DATA_W-1:0]   out_tdata,  // forward_owner, forward_first,
                                                        // forward_second, forward_parent,
                                                        // edge_kept, read_value
  output logic [0:0]                        out_tuser   // forward_valid
);

  // Controller states.
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_RD_VAL   = 4'd1;
  localparam logic [3:0] ST_W_MUL    = 4'd2;
  localparam logic [3:0] ST_W_DEC    = 4'd3;
  localparam logic [3:0] ST_C_WR     = 4'd4;
  localparam logic [3:0] ST_WALK_END = 4'd5;
  localparam logic [3:0] ST_Y_DEC    = 4'd6;
  localparam logic [3:0] ST_RD_A     = 4'd7;
  localparam logic [3:0] ST_RD_B     = 4'd8;
  localparam logic [3:0] ST_FWD      = 4'd9;
  localparam logic [3:0] ST_FINISH   = 4'd10;

  logic [3:0]         state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [drus_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic               out_user_r, out_user_nxt;
  drus_pkg::owner_t   pid_r;
  drus_pkg::count_t   pcnt_r;
  drus_pkg::count_t   cnt_eff;

  // Task registers.
  drus_pkg::vertex_t  y_r, y_nxt;
  drus_pkg::vertex_t  rp_r, rp_nxt;
  drus_pkg::vertex_t  start_r, start_nxt;   // vertex the current walk began at
  drus_pkg::vertex_t  cur_r, cur_nxt;       // walk position, then the root found
  drus_pkg::vertex_t  p_r, p_nxt;           // parent just read during a walk
  drus_pkg::vertex_t  ccur_r, ccur_nxt;     // compression position
  drus_pkg::step_t    steps_r, steps_nxt;
  drus_pkg::step_t    k_r, k_nxt;
  drus_pkg::step_t    k_inc;
  logic               sel_r, sel_nxt;       // 0 while walking x, 1 while walking y
  drus_pkg::vertex_t  rx_r, rx_nxt;
  drus_pkg::vertex_t  ry_r, ry_nxt;
  drus_pkg::vertex_t  a_r, a_nxt;
  drus_pkg::vertex_t  b_val;
  logic               walk_stop;

  // Result fields being assembled.
  logic               res_fv_r, res_fv_nxt;
  drus_pkg::owner_t   res_fo_r, res_fo_nxt;
  drus_pkg::vertex_t  res_ff_r, res_ff_nxt;
  drus_pkg::vertex_t  res_fs_r, res_fs_nxt;
  drus_pkg::vertex_t  res_fp_r, res_fp_nxt;
  logic               res_ek_r, res_ek_nxt;
  drus_pkg::vertex_t  res_rv_r, res_rv_nxt;

  // Parent memory: one write and one registered read per cycle, write-first on a collision.
  drus_pkg::vertex_t  parent_mem [drus_pkg::VERTEX_COUNT];
  logic               mem_we;
  drus_pkg::vertex_t  mem_waddr;
  drus_pkg::vertex_t  mem_wdata;
  drus_pkg::vertex_t  mem_raddr;
  drus_pkg::vertex_t  mem_q_r;
  logic               fwd_hit_r;
  drus_pkg::vertex_t  fwd_data_r;
  drus_pkg::vertex_t  mem_rdata;

  // Shared owner unit; its answer appears in the cycle after the vertex is presented.
  drus_pkg::vertex_t  owner_v;
  drus_pkg::owner_t   owner_rem;

  assign cnt_eff = drus_pkg::eff_count(pcnt_r);

  drus_owner u_owner (
    .clk (clk),
    .v   (owner_v),
    .cnt (cnt_eff),
    .rem (owner_rem)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      parent_mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r    <= parent_mem[mem_raddr];
    fwd_data_r <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else begin
      fwd_hit_r <= mem_we && (mem_waddr == mem_raddr);
    end
  end

  assign mem_rdata = fwd_hit_r ? fwd_data_r : mem_q_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pid_r  <= '0;
      pcnt_r <= drus_pkg::count_t'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        drus_pkg::CFG_PARTITION_ID:    pid_r  <= cfg_wdata[drus_pkg::OWN_W-1:0];
        drus_pkg::CFG_PARTITION_COUNT: pcnt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign k_inc     = k_r + drus_pkg::STEP_W'(1);
  assign b_val     = mem_rdata;
  // A walk ends at a parent owned elsewhere, at a self-parent, or after a full sweep.
  assign walk_stop = (owner_rem != pid_r) || (p_r == cur_r) ||
                     (steps_r == drus_pkg::STEP_W'(drus_pkg::VERTEX_COUNT));

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    y_nxt         = y_r;
    rp_nxt        = rp_r;
    start_nxt     = start_r;
    cur_nxt       = cur_r;
    p_nxt         = p_r;
    ccur_nxt      = ccur_r;
    steps_nxt     = steps_r;
    k_nxt         = k_r;
    sel_nxt       = sel_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    a_nxt         = a_r;
    res_fv_nxt    = res_fv_r;
    res_fo_nxt    = res_fo_r;
    res_ff_nxt    = res_ff_r;
    res_fs_nxt    = res_fs_r;
    res_fp_nxt    = res_fp_r;
    res_ek_nxt    = res_ek_r;
    res_rv_nxt    = res_rv_r;
    mem_we        = 1'b0;
    mem_waddr     = ccur_r;
    mem_wdata     = cur_r;
    mem_raddr     = cur_r;
    owner_v       = mem_rdata;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          y_nxt      = in_tdata[2*drus_pkg::VW-1:drus_pkg::VW];
          rp_nxt     = in_tdata[3*drus_pkg::VW-1:2*drus_pkg::VW];
          res_fv_nxt = 1'b0;
          res_fo_nxt = '0;
          res_ff_nxt = '0;
          res_fs_nxt = '0;
          res_fp_nxt = '0;
          res_ek_nxt = 1'b0;
          res_rv_nxt = '0;
          case (in_tuser)
            drus_pkg::OP_WRITE: begin
              mem_we    = 1'b1;
              mem_waddr = in_tdata[drus_pkg::VW-1:0];
              mem_wdata = in_tdata[2*drus_pkg::VW-1:drus_pkg::VW];
              state_nxt = ST_FINISH;
            end
            drus_pkg::OP_READ: begin
              mem_raddr = in_tdata[drus_pkg::VW-1:0];
              state_nxt = ST_RD_VAL;
            end
            drus_pkg::OP_UNION: begin
              sel_nxt   = 1'b0;
              start_nxt = in_tdata[drus_pkg::VW-1:0];
              cur_nxt   = in_tdata[drus_pkg::VW-1:0];
              steps_nxt = '0;
              mem_raddr = in_tdata[drus_pkg::VW-1:0];
              state_nxt = ST_W_MUL;
            end
            default: begin
              // Unused opcode: an all-zero result.
              state_nxt = ST_FINISH;
            end
          endcase
        end
      end

      ST_RD_VAL: begin
        res_rv_nxt = mem_rdata;
        state_nxt  = ST_FINISH;
      end

      ST_W_MUL: begin
        owner_v   = mem_rdata;
        p_nxt     = mem_rdata;
        state_nxt = ST_W_DEC;
      end

      ST_W_DEC: begin
        if (!walk_stop) begin
          cur_nxt   = p_r;
          steps_nxt = steps_r + drus_pkg::STEP_W'(1);
          mem_raddr = p_r;
          state_nxt = ST_W_MUL;
        end else if ((steps_r != '0) && (start_r != cur_r)) begin
          // Root found; retrace the path from the start and point it at the root.
          ccur_nxt  = start_r;
          k_nxt     = '0;
          mem_raddr = start_r;
          state_nxt = ST_C_WR;
        end else begin
          state_nxt = ST_WALK_END;
        end
      end

      ST_C_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ccur_r;
        mem_wdata = cur_r;
        mem_raddr = mem_rdata;
        if ((k_inc < steps_r) && (mem_rdata != cur_r)) begin
          ccur_nxt = mem_rdata;
          k_nxt    = k_inc;
        end else begin
          state_nxt = ST_WALK_END;
        end
      end

      ST_WALK_END: begin
        if (!sel_r) begin
          rx_nxt    = cur_r;
          owner_v   = y_r;
          state_nxt = ST_Y_DEC;
        end else begin
          ry_nxt    = cur_r;
          mem_raddr = rx_r;
          state_nxt = ST_RD_A;
        end
      end

      ST_Y_DEC: begin
        if (owner_rem == pid_r) begin
          sel_nxt   = 1'b1;
          start_nxt = y_r;
          cur_nxt   = y_r;
          steps_nxt = '0;
          mem_raddr = y_r;
          state_nxt = ST_W_MUL;
        end else begin
          // Remote y: take the parent its owner supplied.
          ry_nxt    = y_r;
          mem_we    = 1'b1;
          mem_waddr = y_r;
          mem_wdata = rp_r;
          mem_raddr = rx_r;
          state_nxt = ST_RD_A;
        end
      end

      ST_RD_A: begin
        a_nxt     = mem_rdata;
        mem_raddr = ry_r;
        state_nxt = ST_RD_B;
      end

      ST_RD_B: begin
        state_nxt = ST_FINISH;
        if (a_r == b_val) begin
          // Already in the same set.
        end else if (a_r == ry_r) begin
          mem_we    = 1'b1;
          mem_waddr = rx_r;
          mem_wdata = b_val;
        end else if (rx_r == b_val) begin
          mem_we    = 1'b1;
          mem_waddr = ry_r;
          mem_wdata = a_r;
        end else if (a_r < b_val) begin
          mem_we    = 1'b1;
          mem_waddr = rx_r;
          mem_wdata = b_val;
          if (rx_r == a_r) begin
            res_ek_nxt = 1'b1;
          end else begin
            // The parent of ry is still b, since rx and ry differ here.
            res_fv_nxt = 1'b1;
            res_ff_nxt = a_r;
            res_fs_nxt = ry_r;
            res_fp_nxt = b_val;
            owner_v    = a_r;
            state_nxt  = ST_FWD;
          end
        end else begin
          res_fv_nxt = 1'b1;
          res_ff_nxt = b_val;
          res_fs_nxt = rx_r;
          res_fp_nxt = a_r;
          owner_v    = b_val;
          state_nxt  = ST_FWD;
        end
      end

      ST_FWD: begin
        res_fo_nxt = owner_rem;
        state_nxt  = ST_FINISH;
      end

      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = res_fv_r;
          out_data_nxt  = {1'b0, res_rv_r, res_ek_r, res_fp_r, res_fs_r, res_ff_r, res_fo_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    y_r        <= y_nxt;
    rp_r       <= rp_nxt;
    start_r    <= start_nxt;
    cur_r      <= cur_nxt;
    p_r        <= p_nxt;
    ccur_r     <= ccur_nxt;
    steps_r    <= steps_nxt;
    k_r        <= k_nxt;
    sel_r      <= sel_nxt;
    rx_r       <= rx_nxt;
    ry_r       <= ry_nxt;
    a_r        <= a_nxt;
    res_fv_r   <= res_fv_nxt;
    res_fo_r   <= res_fo_nxt;
    res_ff_r   <= res_ff_nxt;
    res_fs_r   <= res_fs_nxt;
    res_fp_r   <= res_fp_nxt;
    res_ek_r   <= res_ek_nxt;
    res_rv_r   <= res_rv_nxt;
  end

  // A walk never counts past one full sweep of the vertex range.
  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_W_DEC) |-> (steps_r <= drus_pkg::STEP_W'(drus_pkg::VERTEX_COUNT)))
    else $error("walk step count out of range");

  // Compression rewrites no more entries than the walk followed.
  a_comp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_C_WR) |-> (k_r < steps_r))
    else $error("compression ran past the walked path");

  // Only a write opcode touches the memory in the cycle a word is taken.
  a_accept_write: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser != drus_pkg::OP_WRITE)) |-> !mem_we)
    else $error("memory written on a non-write accept");

  // A forwarded task always passes through the owner lookup.
  a_fwd_path: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RD_B) && res_fv_nxt) |=> (state_r == ST_FWD))
    else $error("forward task skipped owner lookup");

  // New results come only out of the finish state.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FINISH))
    else $error("output loaded outside finish state");

endmodule
